### hdl/byte_ring_buffer_with_rewind_defines.svh
// Assertion macros for the byte ring buffer checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef BYTE_RING_BUFFER_WITH_REWIND_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_REWIND_DEFINES_SVH

// same-cycle implication
`define BRBUF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brbuf: same-cycle check failed");

// next-cycle implication
`define BRBUF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brbuf: next-cycle check failed");

`endif

### hdl/brbuf_pkg.sv
// Shared types and constants for the byte ring buffer.
// No dependencies.
`default_nettype none

package brbuf_pkg;

	localparam int PW        = 11;   // position, count and capacity width
	localparam int DATA_W    = 8;
	localparam int AMT_W     = 12;
	localparam int CAP_RESET = 1024;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_MOVE  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOVE,
		ST_RD_ADDR,
		ST_RD_DATA
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic do_write;
		logic do_query;
		logic load_burst;
		logic load_step;
		logic apply_step;
		logic rd_issue;
		logic rd_take;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic burst_zero;
		logic burst_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

### hdl/byte_ring_buffer_with_rewind.sv
// Byte ring buffer with rewind. Write and query: result in the output register the cycle
// after the beat, one item per cycle unless the output stalls. Move: step registered, then
// applied once the output is free. Read burst: per byte (registered store read, then output
// register). Reset clears control state at once; the byte store is then swept to zero, one
// entry per cycle for all DEPTH entries; no input beat is taken then (capacity writes are).
// Depends on brbuf_pkg, brbuf_ctrl, brbuf_dp and brbuf_ram.
`default_nettype none

module byte_ring_buffer_with_rewind import brbuf_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    capacity_valid,
	output logic                    capacity_ready,
	input  logic [PW-1:0]           capacity,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [DATA_W-1:0]       data_in,
	input  logic signed [AMT_W-1:0] amount,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DATA_W-1:0]       read_data,
	output logic signed [AMT_W-1:0] moved,
	output logic [PW-1:0]           stored_count,
	output logic [PW-1:0]           free_count,
	output logic                    last
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	brbuf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.command (command),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	brbuf_dp #(
		.DEPTH    (DEPTH),
		.MAX_BURST(MAX_BURST)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.data_in       (data_in),
		.amount        (amount),
		.capacity_valid(capacity_valid),
		.capacity_ready(capacity_ready),
		.capacity      (capacity),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.moved         (moved),
		.stored_count  (stored_count),
		.free_count    (free_count),
		.last          (last)
	);

endmodule

`default_nettype wire

### hdl/brbuf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brbuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/brbuf_ctrl.sv
// Controller state machine: sequences clearing, commands and read bursts.
// Depends on brbuf_pkg.
`default_nettype none

module brbuf_ctrl import brbuf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] command,
	output logic       in_stall,
	input  dp_stat_t   st,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = !((state_q == ST_IDLE) && st.out_free);
		accept   = in_valid && !in_stall;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(command))
						CMD_WRITE: cmd.do_write = 1'b1;
						CMD_READ: begin
							cmd.load_burst = 1'b1;
							if (!st.burst_zero) begin
								state_d = ST_RD_ADDR;
							end
						end
						CMD_MOVE: begin
							cmd.load_step = 1'b1;
							state_d       = ST_MOVE;
						end
						CMD_QUERY: cmd.do_query = 1'b1;
						default: cmd.do_query = 1'b1;
					endcase
				end
			end
			ST_MOVE: begin
				if (st.out_free) begin
					cmd.apply_step = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_RD_ADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (st.out_free) begin
					cmd.rd_take = 1'b1;
					state_d     = st.burst_last ? ST_IDLE : ST_RD_ADDR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### hdl/brbuf_dp.sv
// Datapath: capacity, positions, stored count, byte store and result register.
// Depends on brbuf_pkg and brbuf_ram.
`default_nettype none

module brbuf_dp import brbuf_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                st,
	input  logic [DATA_W-1:0]       data_in,
	input  logic signed [AMT_W-1:0] amount,
	input  logic                    capacity_valid,
	output logic                    capacity_ready,
	input  logic [PW-1:0]           capacity,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DATA_W-1:0]       read_data,
	output logic signed [AMT_W-1:0] moved,
	output logic [PW-1:0]           stored_count,
	output logic [PW-1:0]           free_count,
	output logic                    last
);

	localparam int AW = $clog2(DEPTH);
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int SW = AMT_W + 1;
	localparam int MAX_CAP = (1 << PW) - 1;
	localparam logic [PW-1:0] DEPTH_CAP = (DEPTH > MAX_CAP) ? PW'(MAX_CAP) : PW'(DEPTH);
	localparam logic [PW-1:0] CAP_RST = (CAP_RESET > DEPTH) ? DEPTH_CAP : PW'(CAP_RESET);

	logic [PW-1:0]           cap_q, rp_q, wp_q, cnt_q;
	logic [BW-1:0]           rem_q;
	logic [AW-1:0]           clr_q;
	logic signed [AMT_W-1:0] step_q;
	logic                    ov_q;
	logic [DATA_W-1:0]       od_q;
	logic signed [AMT_W-1:0] om_q;
	logic [PW-1:0]           os_q, of_q;
	logic                    ol_q;

	logic [PW-1:0]           free_now, cap_in, wp_inc, rp_inc, wp_nxt, rp_nxt, rp_mv, cnt_mv;
	logic                    can_write, do_store;
	logic [BW-1:0]           want, nburst;
	logic signed [SW-1:0]    amt_x, hi_x, lo_x, step_c, step_x, pos_x, cap_x, cnt_x;
	logic                    load, res_last;
	logic [PW-1:0]           res_cnt;
	logic signed [AMT_W-1:0] res_moved;
	logic [DATA_W-1:0]       res_data, ram_rdata;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [DATA_W-1:0]       ram_wdata;

	assign capacity_ready = 1'b1;
	assign free_now  = cap_q - cnt_q;
	assign can_write = cnt_q < cap_q;
	assign do_store  = cmd.do_write && can_write;

	assign wp_inc = wp_q + PW'(1);
	assign rp_inc = rp_q + PW'(1);
	assign wp_nxt = (wp_inc >= cap_q) ? '0 : wp_inc;
	assign rp_nxt = (rp_inc >= cap_q) ? '0 : rp_inc;

	always_comb begin
		cap_in = (capacity == '0) ? PW'(1) : capacity;
		if (cap_in > DEPTH_CAP) begin
			cap_in = DEPTH_CAP;
		end
	end

	// burst length: saturate request, then limit to what is stored
	always_comb begin
		if (amount < 1) begin
			want = BW'(1);
		end else if (amount > MAX_BURST) begin
			want = BW'(MAX_BURST);
		end else begin
			want = BW'(amount);
		end
		nburst = (PW'(want) > cnt_q) ? BW'(cnt_q) : want;
	end

	// move step clamped to [-free, +stored]
	always_comb begin
		amt_x  = {amount[AMT_W-1], amount};
		hi_x   = $signed({2'b00, cnt_q});
		lo_x   = -$signed({2'b00, free_now});
		step_c = (amt_x > hi_x) ? hi_x : ((amt_x < lo_x) ? lo_x : amt_x);
	end

	always_comb begin
		step_x = {step_q[AMT_W-1], step_q};
		cap_x  = $signed({2'b00, cap_q});
		pos_x  = $signed({2'b00, rp_q}) + step_x;
		cnt_x  = $signed({2'b00, cnt_q}) - step_x;
		cnt_mv = PW'(cnt_x);
		if (pos_x >= cap_x) begin
			rp_mv = PW'(pos_x - cap_x);
		end else if (pos_x[SW-1]) begin
			rp_mv = PW'(pos_x + cap_x);
		end else begin
			rp_mv = PW'(pos_x);
		end
	end

	always_comb begin
		load      = 1'b0;
		res_cnt   = cnt_q;
		res_moved = '0;
		res_data  = '0;
		res_last  = 1'b1;
		if (cmd.do_write) begin
			load = 1'b1;
			if (can_write) begin
				res_cnt   = cnt_q + PW'(1);
				res_moved = AMT_W'(1);
			end
		end
		if (cmd.do_query || (cmd.load_burst && st.burst_zero)) begin
			load = 1'b1;
		end
		if (cmd.apply_step) begin
			load      = 1'b1;
			res_cnt   = cnt_mv;
			res_moved = step_q;
		end
		if (cmd.rd_take) begin
			load      = 1'b1;
			res_data  = ram_rdata;
			res_moved = AMT_W'(1);
			res_cnt   = cnt_q - PW'(1);
			res_last  = st.burst_last;
		end
	end

	assign st.clear_done = clr_q == AW'(DEPTH - 1);
	assign st.burst_zero = nburst == '0;
	assign st.burst_last = rem_q == BW'(1);
	assign st.out_free   = !ov_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			clr_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (capacity_valid) begin
				cap_q <= cap_in;
				rp_q  <= '0;
				wp_q  <= '0;
				cnt_q <= '0;
			end else begin
				if (do_store) begin
					wp_q  <= wp_nxt;
					cnt_q <= cnt_q + PW'(1);
				end
				if (cmd.apply_step) begin
					rp_q  <= rp_mv;
					cnt_q <= cnt_mv;
				end
				if (cmd.rd_take) begin
					rp_q  <= rp_nxt;
					cnt_q <= cnt_q - PW'(1);
				end
			end
			if (cmd.load_burst) begin
				rem_q <= nburst;
			end else if (cmd.rd_take) begin
				rem_q <= rem_q - BW'(1);
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_step) begin
			step_q <= step_c[AMT_W-1:0];
		end
		if (load) begin
			od_q <= res_data;
			om_q <= res_moved;
			os_q <= res_cnt;
			of_q <= cap_q - res_cnt;
			ol_q <= res_last;
		end
	end

	assign ram_we    = cmd.clear_wr || do_store;
	assign ram_waddr = cmd.clear_wr ? clr_q : AW'(wp_q);
	assign ram_wdata = cmd.clear_wr ? '0 : data_in;

	brbuf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_issue),
		.raddr(AW'(rp_q)),
		.rdata(ram_rdata)
	);

	assign out_valid    = ov_q;
	assign read_data    = od_q;
	assign moved        = om_q;
	assign stored_count = os_q;
	assign free_count   = of_q;
	assign last         = ol_q;

endmodule

`default_nettype wire

### hdl/brbuf_checker.sv
// Port-level checker for the byte ring buffer, bound to the top level.
// Depends on brbuf_pkg and byte_ring_buffer_with_rewind_defines.svh.
`default_nettype none
`include "byte_ring_buffer_with_rewind_defines.svh"

module brbuf_checker import brbuf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [1:0]              command,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [DATA_W-1:0]       read_data,
	input logic signed [AMT_W-1:0] moved,
	input logic                    last
);

	// stalled result beat holds
	`BRBUF_ASSERT_NXT(a_out_hold, out_valid && out_stall, $stable({out_valid, read_data, moved, last}))

	// only burst bytes carry data
	`BRBUF_ASSERT_IMP(a_data_is_byte, out_valid && (read_data != 8'd0), moved == 12'sd1)

	// only bursts produce more than one result per item
	`BRBUF_ASSERT_IMP(a_burst_only, out_valid && !last, moved == 12'sd1)

	// a taken move stalls the input until its step is applied
	`BRBUF_ASSERT_NXT(a_move_busy, in_valid && !in_stall && (command == CMD_MOVE), in_stall)

endmodule

bind byte_ring_buffer_with_rewind brbuf_checker u_brbuf_checker (.*);

`default_nettype wire
